// ===== design/sled_pkg.sv =====
`default_nettype none

package sled_pkg;

  // grid geometry
  localparam int GridSide  = 5;
  localparam int CellCount = GridSide * GridSide;
  localparam int SlotW     = $clog2(CellCount);
  localparam int CoordW    = $clog2(GridSide);

  // color channels: green in the top bits, then red, then blue
  localparam int LevelW   = 3;
  localparam int LevelMax = 4;
  localparam int ColorW   = 3 * LevelW;

  // stream widths
  localparam int InDataW  = 64;
  localparam int OutDataW = 16;
  localparam int SlotOutW = 5;

  typedef enum logic [1:0] {
    CMD_FILL  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_EMIT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_CLEAR,
    ST_EMIT
  } state_e;

  // control handed to every cell of the ring, plus the value entering the tail
  typedef struct packed {
    logic              shift;
    logic [ColorW-1:0] data;
  } ring_ctrl_t;

  // saturate a signed coordinate into the grid
  function automatic logic [CoordW-1:0] clamp_coord(input logic signed [7:0] v);
    logic [CoordW-1:0] res;
    if (v < 8'sd0) begin
      res = '0;
    end else if (v > $signed(8'(GridSide - 1))) begin
      res = CoordW'(GridSide - 1);
    end else begin
      res = CoordW'(v);
    end
    return res;
  endfunction

  // saturate a channel level
  function automatic logic [LevelW-1:0] sat_level(input logic [7:0] v);
    logic [LevelW-1:0] res;
    if (v > 8'(LevelMax)) begin
      res = LevelW'(LevelMax);
    end else begin
      res = LevelW'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/serpentine_led_frame_buffer.sv =====
// Frame store for a serpentine-wired RGB LED matrix (GridSide x GridSide).
// Commands arrive on the s_axis channel, one transaction each: fill a
// rectangle (or one pixel) with a color, clear the store, or emit the frame.
// Emitted entries leave on the m_axis channel in chain order, one
// transaction per LED; tlast marks the last LED of the frame.
// The store is a ring of cells that rotates one position per cycle during a
// fill or clear, and during an emit whenever the output register is free;
// fill, clear and emit each walk the whole ring once, and no new command is
// taken until that walk is done.
// s_axis_tready is high only while no command is in progress; an unused
// command code is taken and does nothing.
// Once the emit command is taken, the block enters its emit state and, when
// the output register is free, registers the first result there; results
// then follow one per cycle while m_axis_tready stays high.
// When the receiver stalls, the ring stops with the next entry at its head
// and the pending result holds in the output register until taken.
// Reset clears every entry of the store to black and drops m_axis_tvalid.
`default_nettype none

module serpentine_led_frame_buffer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // cmd[1:0], corner_a_col[9:2], corner_a_row[17:10], corner_b_col[25:18],
  // corner_b_row[33:26], red_level[41:34], green_level[49:42],
  // blue_level[57:50], zero[63:58]
  input  wire logic [sled_pkg::InDataW-1:0]    s_axis_tdata,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // led_slot[4:0], out_green[7:5], out_red[10:8], out_blue[13:11],
  // zero[15:14]
  output logic [sled_pkg::OutDataW-1:0]        m_axis_tdata,
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready
);

  localparam int N = sled_pkg::CellCount;

  sled_pkg::ring_ctrl_t          ring_ctrl;
  logic [sled_pkg::ColorW-1:0]   cell_data [N];

  logic [sled_pkg::SlotOutW-1:0] led_slot;
  logic [sled_pkg::LevelW-1:0]   out_green, out_red, out_blue;

  // command decode and ring sequencing
  sled_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (s_axis_tvalid),
    .cmd_ready_o    (s_axis_tready),
    .cmd_i          (s_axis_tdata[1:0]),
    .corner_a_col_i (s_axis_tdata[9:2]),
    .corner_a_row_i (s_axis_tdata[17:10]),
    .corner_b_col_i (s_axis_tdata[25:18]),
    .corner_b_row_i (s_axis_tdata[33:26]),
    .red_level_i    (s_axis_tdata[41:34]),
    .green_level_i  (s_axis_tdata[49:42]),
    .blue_level_i   (s_axis_tdata[57:50]),
    .head_i         (cell_data[0]),
    .ring_o         (ring_ctrl),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .led_slot_o     (led_slot),
    .out_green_o    (out_green),
    .out_red_o      (out_red),
    .out_blue_o     (out_blue),
    .frame_end_o    (m_axis_tlast)
  );

  // ring of cells: each hands its entry toward the head, the tail takes the
  // rewritten head entry
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_tail
      sled_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ring_ctrl),
        .data_i (ring_ctrl.data),
        .data_o (cell_data[i])
      );
    end else begin : g_body
      sled_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ring_ctrl),
        .data_i (cell_data[i+1]),
        .data_o (cell_data[i])
      );
    end
  end

  assign m_axis_tdata = {2'b00, out_blue, out_red, out_green, led_slot};

endmodule

`default_nettype wire

// ===== design/sled_cell.sv =====
`default_nettype none

module sled_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sled_pkg::ring_ctrl_t          ctrl_i,
  input  wire logic [sled_pkg::ColorW-1:0]   data_i,
  output logic      [sled_pkg::ColorW-1:0]   data_o
);

  logic [sled_pkg::ColorW-1:0] data_q;
  logic [sled_pkg::ColorW-1:0] data_d;

  // take the neighbor's entry whenever the ring moves
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift) begin
      data_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== design/sled_seq.sv =====
`default_nettype none

module sled_seq (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // command side
  input  wire logic                              cmd_valid_i,
  output logic                                   cmd_ready_o,
  input  wire logic [1:0]                        cmd_i,
  input  wire logic signed [7:0]                 corner_a_col_i,
  input  wire logic signed [7:0]                 corner_a_row_i,
  input  wire logic signed [7:0]                 corner_b_col_i,
  input  wire logic signed [7:0]                 corner_b_row_i,
  input  wire logic [7:0]                        red_level_i,
  input  wire logic [7:0]                        green_level_i,
  input  wire logic [7:0]                        blue_level_i,
  // ring
  input  wire logic [sled_pkg::ColorW-1:0]       head_i,
  output sled_pkg::ring_ctrl_t                   ring_o,
  // result side
  output logic                                   res_valid_o,
  input  wire logic                              res_ready_i,
  output logic [sled_pkg::SlotOutW-1:0]          led_slot_o,
  output logic [sled_pkg::LevelW-1:0]            out_green_o,
  output logic [sled_pkg::LevelW-1:0]            out_red_o,
  output logic [sled_pkg::LevelW-1:0]            out_blue_o,
  output logic                                   frame_end_o
);

  localparam int CW = sled_pkg::CoordW;
  localparam int LW = sled_pkg::LevelW;

  sled_pkg::state_e state_q, state_d;

  logic [sled_pkg::SlotW-1:0]  slot_q, slot_d;
  logic [CW-1:0]               row_q, row_d;
  logic [CW-1:0]               pos_q, pos_d;
  logic [CW-1:0]               c_lo_q, c_hi_q, r_lo_q, r_hi_q;
  logic [sled_pkg::ColorW-1:0] color_q;

  logic                        res_valid_q, res_valid_d;
  logic [sled_pkg::SlotOutW-1:0] res_slot_q;
  logic [sled_pkg::ColorW-1:0] res_color_q;
  logic                        res_last_q;

  logic            accept;
  logic            step;
  logic            last_step;
  logic            out_free;
  logic            covered;
  logic [CW-1:0]   col;
  logic [CW-1:0]   ca, cb, ra, rb;

  assign accept    = cmd_valid_i && cmd_ready_o;
  assign out_free  = !res_valid_q || res_ready_i;
  assign last_step = (slot_q == sled_pkg::SlotW'(sled_pkg::CellCount - 1));

  // one ring position per cycle; emit waits for room in the output register
  always_comb begin
    unique case (state_q)
      sled_pkg::ST_FILL,
      sled_pkg::ST_CLEAR: step = 1'b1;
      sled_pkg::ST_EMIT:  step = out_free;
      default:            step = 1'b0;
    endcase
  end

  // column of the head entry: even rows run right to left
  assign col = row_q[0] ? pos_q : CW'(sled_pkg::GridSide - 1) - pos_q;

  assign covered = (row_q >= r_lo_q) && (row_q <= r_hi_q) &&
                   (col >= c_lo_q) && (col <= c_hi_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sled_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (sled_pkg::cmd_e'(cmd_i))
            sled_pkg::CMD_FILL:  state_d = sled_pkg::ST_FILL;
            sled_pkg::CMD_CLEAR: state_d = sled_pkg::ST_CLEAR;
            sled_pkg::CMD_EMIT:  state_d = sled_pkg::ST_EMIT;
            default:             state_d = sled_pkg::ST_IDLE;
          endcase
        end
      end
      default: begin
        if (step && last_step) begin
          state_d = sled_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // outputs toward the ring and the command side
  always_comb begin
    cmd_ready_o  = 1'b0;
    ring_o.shift = step;
    ring_o.data  = head_i;
    unique case (state_q)
      sled_pkg::ST_IDLE:  cmd_ready_o = 1'b1;
      sled_pkg::ST_CLEAR: ring_o.data = '0;
      sled_pkg::ST_FILL: begin
        if (covered) begin
          ring_o.data = color_q;
        end
      end
      default: ring_o.data = head_i;
    endcase
  end

  // position counters
  always_comb begin
    slot_d = slot_q;
    row_d  = row_q;
    pos_d  = pos_q;
    if (step) begin
      if (last_step) begin
        slot_d = '0;
        row_d  = '0;
        pos_d  = '0;
      end else begin
        slot_d = slot_q + 1'b1;
        if (pos_q == CW'(sled_pkg::GridSide - 1)) begin
          pos_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  // output register valid
  always_comb begin
    res_valid_d = res_valid_q;
    if (state_q == sled_pkg::ST_EMIT && step) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sled_pkg::ST_IDLE;
      slot_q      <= '0;
      row_q       <= '0;
      pos_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      row_q       <= row_d;
      pos_q       <= pos_d;
      res_valid_q <= res_valid_d;
    end
  end

  // clamped corners
  assign ca = sled_pkg::clamp_coord(corner_a_col_i);
  assign cb = sled_pkg::clamp_coord(corner_b_col_i);
  assign ra = sled_pkg::clamp_coord(corner_a_row_i);
  assign rb = sled_pkg::clamp_coord(corner_b_row_i);

  // operands, ordered per axis
  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_lo_q  <= (ca > cb) ? cb : ca;
      c_hi_q  <= (ca > cb) ? ca : cb;
      r_lo_q  <= (ra > rb) ? rb : ra;
      r_hi_q  <= (ra > rb) ? ra : rb;
      color_q <= {sled_pkg::sat_level(green_level_i),
                  sled_pkg::sat_level(red_level_i),
                  sled_pkg::sat_level(blue_level_i)};
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == sled_pkg::ST_EMIT && step) begin
      res_slot_q  <= sled_pkg::SlotOutW'(slot_q);
      res_color_q <= head_i;
      res_last_q  <= last_step;
    end
  end

  assign res_valid_o = res_valid_q;
  assign led_slot_o  = res_slot_q;
  assign out_green_o = res_color_q[3*LW-1:2*LW];
  assign out_red_o   = res_color_q[2*LW-1:LW];
  assign out_blue_o  = res_color_q[LW-1:0];
  assign frame_end_o = res_last_q;

  // row and position counters stay inside the grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q < CW'(sled_pkg::GridSide)) && (pos_q < CW'(sled_pkg::GridSide)))
    else $error("ring position counter left the grid");

  // a command always ends with the counters back at the first slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sled_pkg::ST_IDLE) && (state_d == sled_pkg::ST_IDLE)
    |=> (slot_q == '0) && (row_q == '0) && (pos_q == '0))
    else $error("command finished away from the first slot");

  // the frame marker only travels with the last slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_last_q
    |-> (res_slot_q == sled_pkg::SlotOutW'(sled_pkg::CellCount - 1)))
    else $error("frame end on a slot other than the last");

  // the ring moves only while a command is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_o.shift |-> (state_q != sled_pkg::ST_IDLE))
    else $error("ring shifted while idle");

endmodule

`default_nettype wire
